### rtl/pscc_pkg.sv
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared widths and result codes for the polyline self-cross check.
// ----------------------------------------------------------------------------
package pscc_pkg;

    localparam int COORD_IN_W = 16;   // width of a coordinate field on the port
    localparam int TOTAL_W    = 6;    // width of the vertex total field
    localparam int REASON_W   = 3;

    typedef logic [REASON_W-1:0] reason_t;

    localparam reason_t RSN_OK     = 3'd0;
    localparam reason_t RSN_ZERO   = 3'd1;
    localparam reason_t RSN_REPEAT = 3'd2;
    localparam reason_t RSN_CROSS  = 3'd3;
    localparam reason_t RSN_FULL   = 3'd4;

    localparam logic CMD_CLEAR   = 1'b0;
    localparam logic CMD_PROPOSE = 1'b1;

endpackage

### rtl/pscc_ram.sv
// ----------------------------------------------------------------------------
// pscc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pscc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/polyline_self_cross_check_top.sv
// ----------------------------------------------------------------------------
// polyline_self_cross_check_top
// Builds a simple polyline one vertex at a time and refuses vertices that
// would make it degenerate or self-intersecting.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_command, s_pos_x, s_pos_y
//  m_      | out       | m_valid / m_ready | m_accepted, m_reason, m_vertex_total
//
//  A clear, a full store, an empty store or a zero-length proposal goes
//  straight to the final step. Any other proposal scans the store first:
//  the vertex store has one read port and every stored vertex is read once.
//  Reset (aresetn low, synchronous) empties the polyline; store needs no sweep.
//  A new word is taken while the previous result waits in the output register;
//  a result stalls in the final step until the output register is free.
// ----------------------------------------------------------------------------
module polyline_self_cross_check_top #(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_command,
    input  logic signed [pscc_pkg::COORD_IN_W-1:0]     s_pos_x,
    input  logic signed [pscc_pkg::COORD_IN_W-1:0]     s_pos_y,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic                                       m_accepted,
    output pscc_pkg::reason_t                          m_reason,
    output logic [pscc_pkg::TOTAL_W-1:0]               m_vertex_total
);

    import pscc_pkg::*;

    // stored coordinate width: wider settings change nothing for 16-bit fields
    localparam int CW   = (COORD_WIDTH < COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int PW   = 2 * DW;          // product
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIN} state_t;

    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    // c inside the bounding box of a-b
    function automatic logic in_box(
        input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
        input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
        input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
        logic signed [CW-1:0] lox, hix, loy, hiy;
        lox = (ax < bx) ? ax : bx;
        hix = (ax < bx) ? bx : ax;
        loy = (ay < by) ? ay : by;
        hiy = (ay < by) ? by : ay;
        return (cx >= lox) && (cx <= hix) && (cy >= loy) && (cy <= hiy);
    endfunction

    // ---------------------------------------------------------------- control
    state_t                 state_reg;
    logic [CNTW-1:0]        count_reg;
    logic [CNTW-1:0]        count_next;
    logic [CNTW-1:0]        rd_cnt_reg;
    logic                   cmd_reg;
    reason_t                rsn_reg;
    reason_t                rsn_next;
    logic                   m_valid_reg;
    logic                   m_accepted_reg;
    reason_t                m_reason_reg;
    logic [TOTAL_W-1:0]     m_total_reg;
    logic [CNTW+TOTAL_W-1:0] total_ext;

    // ---------------------------------------------------------------- item
    logic signed [CW-1:0]   qx_in, qy_in;
    logic signed [CW-1:0]   q_x_reg, q_y_reg;
    logic signed [CW-1:0]   last_x_reg, last_y_reg;
    logic signed [CW-1:0]   prev_x_reg, prev_y_reg;
    logic signed [DW-1:0]   uq_x_reg, uq_y_reg;       // Q - L
    logic signed [DW-1:0]   pv_x_reg, pv_y_reg;       // P - L

    // ---------------------------------------------------------------- memory
    logic                   rd_en;
    logic                   mem_we;
    logic                   fin_go;
    logic                   in_fire;
    logic [2*CW-1:0]        rd_data;
    logic signed [CW-1:0]   b_x, b_y;

    // ---------------------------------------------------------------- scan pipe
    logic                   rd_vld_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   seg_ok;
    logic signed [CW-1:0]   a_x_reg, a_y_reg;
    logic                   s1_seg_reg, s2_seg_reg;
    logic signed [DW-1:0]   e_x_reg, e_y_reg, la_x_reg, la_y_reg, qa_x_reg, qa_y_reg;
    logic signed [DW-1:0]   al_x_reg, al_y_reg, bl_x_reg, bl_y_reg;
    logic [3:0]             box1_reg, box2_reg;
    logic signed [PW-1:0]   prod_reg [8];
    logic signed [PW:0]     orient_v [4];
    logic [3:0]             o_pos, o_neg, o_zero;
    logic                   touch;
    logic                   rep_any_reg, cross_any_reg;
    logic                   scan_busy;

    // ---------------------------------------------------------------- previous segment
    logic signed [PW-1:0]   pc1_reg, pc2_reg, pd1_reg, pd2_reg;
    logic signed [PW:0]     p_cross, p_dot;
    logic                   prev_bad;

    assign qx_in   = s_pos_x[CW-1:0];
    assign qy_in   = s_pos_y[CW-1:0];
    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign rd_en   = (state_reg == ST_SCAN);
    assign fin_go  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign mem_we  = fin_go && (cmd_reg == CMD_PROPOSE) && (rsn_reg == RSN_OK);

    assign b_x = rd_data[2*CW-1:CW];
    assign b_y = rd_data[CW-1:0];

    assign count_next = (cmd_reg == CMD_CLEAR) ? '0 :
                        (rsn_reg == RSN_OK)    ? count_reg + CNTW'(1) : count_reg;
    assign total_ext  = (CNTW+TOTAL_W)'(count_next);

    assign scan_busy  = rd_vld_reg || s1_seg_reg || s2_seg_reg;

    // repeat beats crossing; the previous segment only counts with two vertices
    always_comb begin
        if (rep_any_reg) begin
            rsn_next = RSN_REPEAT;
        end else if (cross_any_reg || ((count_reg >= CNTW'(2)) && prev_bad)) begin
            rsn_next = RSN_CROSS;
        end else begin
            rsn_next = RSN_OK;
        end
    end

    pscc_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({q_x_reg, q_y_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------- FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !fin_go) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        cmd_reg    <= s_command;
                        rd_cnt_reg <= '0;
                        if (s_command == CMD_CLEAR) begin
                            rsn_reg   <= RSN_OK;
                            state_reg <= ST_FIN;
                        end else if (count_reg == CNTW'(MAX_VERTICES)) begin
                            rsn_reg   <= RSN_FULL;
                            state_reg <= ST_FIN;
                        end else if (count_reg == '0) begin
                            rsn_reg   <= RSN_OK;
                            state_reg <= ST_FIN;
                        end else if (qx_in == last_x_reg && qy_in == last_y_reg) begin
                            rsn_reg   <= RSN_ZERO;
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    rd_cnt_reg <= rd_cnt_reg + CNTW'(1);
                    if (rd_cnt_reg + CNTW'(1) == count_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!scan_busy) begin
                        rsn_reg   <= rsn_next;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        m_valid_reg    <= 1'b1;
                        m_accepted_reg <= (cmd_reg == CMD_CLEAR) || (rsn_reg == RSN_OK);
                        m_reason_reg   <= rsn_reg;
                        m_total_reg    <= total_ext[TOTAL_W-1:0];
                        count_reg      <= count_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accepted     = m_accepted_reg;
    assign m_reason       = m_reason_reg;
    assign m_vertex_total = m_total_reg;

    // ---------------------------------------------------------------- item regs
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            q_x_reg  <= qx_in;
            q_y_reg  <= qy_in;
            uq_x_reg <= sx(qx_in) - sx(last_x_reg);
            uq_y_reg <= sx(qy_in) - sx(last_y_reg);
            pv_x_reg <= sx(prev_x_reg) - sx(last_x_reg);
            pv_y_reg <= sx(prev_y_reg) - sx(last_y_reg);
        end
        if (mem_we) begin
            prev_x_reg <= last_x_reg;
            prev_y_reg <= last_y_reg;
            last_x_reg <= q_x_reg;
            last_y_reg <= q_y_reg;
        end
        // previous segment: collinear and turning back means positive dot
        pc1_reg <= uq_x_reg * pv_y_reg;
        pc2_reg <= uq_y_reg * pv_x_reg;
        pd1_reg <= uq_x_reg * pv_x_reg;
        pd2_reg <= uq_y_reg * pv_y_reg;
    end

    assign p_cross  = pc1_reg - pc2_reg;
    assign p_dot    = pd1_reg + pd2_reg;
    assign prev_bad = (p_cross == '0) && (p_dot > 0);

    // ---------------------------------------------------------------- scan pipe
    // S0: read word arrives, B = store[i], A = store[i-1]; segment A-B is
    // tested when it does not share the start vertex of the new segment.
    assign seg_ok = rd_vld_reg && (rd_idx_reg != '0) &&
                    ((CNTW'(rd_idx_reg) + CNTW'(1)) < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            s1_seg_reg <= 1'b0;
            s2_seg_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            s1_seg_reg <= seg_ok;
            s2_seg_reg <= s1_seg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_cnt_reg[AW-1:0];
        if (rd_vld_reg) begin
            a_x_reg <= b_x;
            a_y_reg <= b_y;
        end
        // S0 -> S1: differences and bounding box flags
        e_x_reg  <= sx(b_x) - sx(a_x_reg);
        e_y_reg  <= sx(b_y) - sx(a_y_reg);
        la_x_reg <= sx(last_x_reg) - sx(a_x_reg);
        la_y_reg <= sx(last_y_reg) - sx(a_y_reg);
        qa_x_reg <= sx(q_x_reg) - sx(a_x_reg);
        qa_y_reg <= sx(q_y_reg) - sx(a_y_reg);
        al_x_reg <= sx(a_x_reg) - sx(last_x_reg);
        al_y_reg <= sx(a_y_reg) - sx(last_y_reg);
        bl_x_reg <= sx(b_x) - sx(last_x_reg);
        bl_y_reg <= sx(b_y) - sx(last_y_reg);
        box1_reg <= {in_box(last_x_reg, last_y_reg, q_x_reg, q_y_reg, b_x, b_y),
                     in_box(last_x_reg, last_y_reg, q_x_reg, q_y_reg, a_x_reg, a_y_reg),
                     in_box(a_x_reg, a_y_reg, b_x, b_y, q_x_reg, q_y_reg),
                     in_box(a_x_reg, a_y_reg, b_x, b_y, last_x_reg, last_y_reg)};
        // S1 -> S2: products of the four orientation tests
        prod_reg[0] <= e_x_reg * la_y_reg;
        prod_reg[1] <= e_y_reg * la_x_reg;
        prod_reg[2] <= e_x_reg * qa_y_reg;
        prod_reg[3] <= e_y_reg * qa_x_reg;
        prod_reg[4] <= uq_x_reg * al_y_reg;
        prod_reg[5] <= uq_y_reg * al_x_reg;
        prod_reg[6] <= uq_x_reg * bl_y_reg;
        prod_reg[7] <= uq_y_reg * bl_x_reg;
        box2_reg    <= box1_reg;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            orient_v[k] = prod_reg[2*k] - prod_reg[2*k+1];
            o_neg[k]    = orient_v[k][PW];
            o_zero[k]   = (orient_v[k] == '0);
            o_pos[k]    = !o_neg[k] && !o_zero[k];
        end
        touch = (((o_pos[0] && o_neg[1]) || (o_neg[0] && o_pos[1])) &&
                 ((o_pos[2] && o_neg[3]) || (o_neg[2] && o_pos[3]))) ||
                |(o_zero & box2_reg);
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rep_any_reg   <= 1'b0;
            cross_any_reg <= 1'b0;
        end else begin
            if (rd_vld_reg && b_x == q_x_reg && b_y == q_y_reg) begin
                rep_any_reg <= 1'b1;
            end
            if (s2_seg_reg && touch) begin
                cross_any_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (rd_cnt_reg < count_reg))
        else $error("read of an unwritten store entry");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (count_reg < CNTW'(MAX_VERTICES)))
        else $error("append into a full store");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_go && cmd_reg == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear left vertices behind");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid_reg && !m_ready) |=> (state_reg == ST_FIN))
        else $error("result dropped while output word is stalled");

endmodule
